>>> hw/rtl/ttp_pkg.sv
// ttp_pkg: types, codes and constants of the tagged token parser
// no dependencies; used by the channel interfaces and all ttp modules

package ttp_pkg;

   // token kinds as given by the mode field at the first byte of a token
   localparam logic [2:0] KIND_INT32  = 3'd0;
   localparam logic [2:0] KIND_INT64  = 3'd1;
   localparam logic [2:0] KIND_UINT64 = 3'd2;
   localparam logic [2:0] KIND_BOOL   = 3'd3;
   localparam logic [2:0] KIND_CHAR   = 3'd4;
   localparam logic [2:0] KIND_STRING = 3'd5;

   // ascii characters of the token grammar
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_NONE  = 8'h00;

   // number range limits
   localparam logic [63:0] LIM_INT32_POS = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] LIM_INT32_NEG = 64'h0000_0000_8000_0000;
   localparam logic [63:0] LIM_INT64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM_INT64_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] LIM_UINT64    = 64'hFFFF_FFFF_FFFF_FFFF;

   // parse phase, one-hot
   typedef enum logic [8:0] {
      PH_TAG   = 9'b0_0000_0001,
      PH_COLON = 9'b0_0000_0010,
      PH_NUM   = 9'b0_0000_0100,
      PH_BVAL  = 9'b0_0000_1000,
      PH_CVAL  = 9'b0_0001_0000,
      PH_TERM  = 9'b0_0010_0000,
      PH_SLEN  = 9'b0_0100_0000,
      PH_SBODY = 9'b0_1000_0000,
      PH_STERM = 9'b1_0000_0000
   } phase_type;

   typedef enum logic [2:0] {
      ST_VALUE        = 3'd0,
      ST_STRING_BYTE  = 3'd1,
      ST_STRING_DONE  = 3'd2,
      ST_BAD_TAG      = 3'd3,
      ST_BAD_NUMBER   = 3'd4,
      ST_BAD_TERM     = 3'd5,
      ST_TRUNCATED    = 3'd6,
      ST_STRING_LONG  = 3'd7
   } status_type;

   // parser state that does not depend on the string length parameter
   typedef struct packed {
      phase_type   phase;
      logic [2:0]  kind;
      logic [63:0] magnitude;
      logic        is_negative;
      logic        saw_digit;
      logic        skipping;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] value;
      logic [7:0]  content_byte;
      logic        last;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_TAG,
      kind:        3'd0,
      magnitude:   64'd0,
      is_negative: 1'b0,
      saw_digit:   1'b0,
      skipping:    1'b0
   };

   // tag letter expected for a kind, CH_NONE for kinds without a tag
   function automatic logic [7:0] tag_for_kind(input logic [2:0] kind);
      logic [7:0] tag;
      unique case (kind) inside
         KIND_INT32:                tag = CH_I;
         KIND_INT64, KIND_UINT64:   tag = CH_L;
         KIND_BOOL:                 tag = CH_B;
         KIND_CHAR:                 tag = CH_C;
         KIND_STRING:               tag = CH_S;
         default:                   tag = CH_NONE;
      endcase
      return tag;
   endfunction

endpackage

>>> hw/rtl/ttp_channels.sv
// ttp_channels: valid/ready interfaces of the request and response channels
// depends on ttp_pkg

interface ttp_req_if
   import ttp_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] data_byte;
   logic       end_of_data;

   modport source (output valid, output mode, output data_byte, output end_of_data,
                   input ready);
   modport sink   (input valid, input mode, input data_byte, input end_of_data,
                   output ready);
endinterface

interface ttp_rsp_if
   import ttp_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] value;
   logic [7:0]  content_byte;
   logic        last;

   modport source (output valid, output status, output value, output content_byte,
                   output last, input ready);
   modport sink   (input valid, input status, input value, input content_byte,
                   input last, output ready);
endinterface

>>> hw/rtl/ttp_accum.sv
// ttp_accum: decimal accumulate (magnitude * 10 + digit) and range check
// depends on ttp_pkg

module ttp_accum
   import ttp_pkg::*;
(
   input  logic [63:0] magnitude,
   input  logic [3:0]  digit,
   input  logic [63:0] limit,
   output logic [63:0] sum,
   output logic        over
);

   logic [67:0] wide_sum;

   // times ten as two shifts and an add, kept wide so nothing wraps
   assign wide_sum = ({magnitude, 3'b000} + {3'b000, magnitude, 1'b0}) + 68'(digit);
   assign sum      = wide_sum[63:0];
   assign over     = wide_sum > {4'd0, limit};

endmodule

>>> hw/rtl/ttp_step.sv
// ttp_step: next parser state and result record for one byte
// depends on ttp_pkg and ttp_accum

module ttp_step
   import ttp_pkg::*;
#(
   parameter logic [31:0] MAX_STRING_LEN = 32'd65535,
   parameter int          LEN_W          = 16
) (
   input  state_type        cur,
   input  logic [LEN_W-1:0] bytes_left_cur,
   input  logic [2:0]       mode,
   input  logic [7:0]       data_byte,
   input  logic             end_of_data,
   output state_type        nxt,
   output logic [LEN_W-1:0] bytes_left_nxt,
   output logic             emit,
   output result_type       result
);

   logic        is_digit;
   logic [3:0]  digit;
   logic [63:0] limit;
   logic [63:0] acc_sum;
   logic        acc_over;
   logic        done;
   logic        err;
   logic [7:0]  tag;

   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign digit    = 4'(data_byte - CH_ZERO);
   assign tag      = tag_for_kind(mode);

   always_comb begin
      if (cur.phase == PH_SLEN) begin
         limit = {32'd0, MAX_STRING_LEN};
      end else if (cur.kind == KIND_INT32) begin
         limit = cur.is_negative ? LIM_INT32_NEG : LIM_INT32_POS;
      end else if (cur.kind == KIND_INT64) begin
         limit = cur.is_negative ? LIM_INT64_NEG : LIM_INT64_POS;
      end else begin
         limit = LIM_UINT64;
      end
   end

   ttp_accum u_accum (
      .magnitude (cur.magnitude),
      .digit     (digit),
      .limit     (limit),
      .sum       (acc_sum),
      .over      (acc_over)
   );

   always_comb begin
      nxt                 = cur;
      bytes_left_nxt      = bytes_left_cur;
      emit                = 1'b0;
      done                = 1'b0;
      err                 = 1'b0;
      result.status       = ST_VALUE;
      result.value        = 64'd0;
      result.content_byte = 8'd0;
      result.last         = 1'b1;

      if (cur.skipping) begin
         // drop bytes until the end of the buffer
         if (end_of_data) begin
            nxt.skipping = 1'b0;
            nxt.phase    = PH_TAG;
         end
      end else begin
         unique case (cur.phase)
            PH_COLON: begin
               if (data_byte != CH_COLON) begin
                  err = 1'b1; result.status = ST_BAD_TAG;
               end else if (cur.kind <= KIND_UINT64) begin
                  nxt.phase = PH_NUM;
               end else if (cur.kind == KIND_BOOL) begin
                  nxt.phase = PH_BVAL;
               end else if (cur.kind == KIND_CHAR) begin
                  nxt.phase = PH_CVAL;
               end else begin
                  nxt.phase = PH_SLEN;
               end
            end
            PH_NUM: begin
               if (data_byte == CH_SEMI) begin
                  if (!cur.saw_digit) begin
                     err = 1'b1; result.status = ST_BAD_NUMBER;
                  end else begin
                     result.value = cur.is_negative ? (64'd0 - cur.magnitude) : cur.magnitude;
                     emit = 1'b1; done = 1'b1;
                  end
               end else if (data_byte == CH_MINUS && cur.kind <= KIND_INT64 &&
                            !cur.saw_digit && !cur.is_negative) begin
                  nxt.is_negative = 1'b1;
               end else if (is_digit) begin
                  if (acc_over) begin
                     err = 1'b1; result.status = ST_BAD_NUMBER;
                  end else begin
                     nxt.magnitude = acc_sum;
                     nxt.saw_digit = 1'b1;
                  end
               end else begin
                  err = 1'b1; result.status = ST_BAD_NUMBER;
               end
            end
            PH_BVAL: begin
               if (data_byte != CH_ZERO && data_byte != CH_ONE) begin
                  err = 1'b1; result.status = ST_BAD_NUMBER;
               end else begin
                  nxt.magnitude = {63'd0, data_byte == CH_ONE};
                  nxt.phase     = PH_TERM;
               end
            end
            PH_CVAL: begin
               nxt.magnitude = {56'd0, data_byte};
               nxt.phase     = PH_TERM;
            end
            PH_TERM: begin
               if (data_byte != CH_SEMI) begin
                  err = 1'b1; result.status = ST_BAD_TERM;
               end else begin
                  result.value = cur.magnitude;
                  result.content_byte = (cur.kind == KIND_CHAR) ? cur.magnitude[7:0] : 8'd0;
                  emit = 1'b1; done = 1'b1;
               end
            end
            PH_SLEN: begin
               if (data_byte == CH_COLON) begin
                  if (!cur.saw_digit) begin
                     err = 1'b1; result.status = ST_BAD_NUMBER;
                  end else begin
                     // magnitude never passes the limit here, so it fits the counter
                     bytes_left_nxt = cur.magnitude[LEN_W-1:0];
                     nxt.phase = (cur.magnitude != 64'd0) ? PH_SBODY : PH_STERM;
                  end
               end else if (is_digit) begin
                  nxt.magnitude = acc_sum;
                  nxt.saw_digit = 1'b1;
                  if (acc_over) begin
                     err = 1'b1; result.status = ST_STRING_LONG;
                  end
               end else begin
                  err = 1'b1; result.status = ST_BAD_NUMBER;
               end
            end
            PH_SBODY: begin
               emit = 1'b1;
               result.status       = ST_STRING_BYTE;
               result.content_byte = data_byte;
               result.last         = 1'b0;
               bytes_left_nxt      = bytes_left_cur - LEN_W'(1);
               if (bytes_left_cur == LEN_W'(1)) begin
                  nxt.phase = PH_STERM;
               end
            end
            PH_STERM: begin
               if (data_byte != CH_SEMI) begin
                  err = 1'b1; result.status = ST_BAD_TERM;
               end else begin
                  result.status = ST_STRING_DONE;
                  result.value  = cur.magnitude;
                  emit = 1'b1; done = 1'b1;
               end
            end
            default: begin
               // expect tag: latch the kind and clear the token state
               nxt.kind        = mode;
               nxt.magnitude   = 64'd0;
               nxt.is_negative = 1'b0;
               nxt.saw_digit   = 1'b0;
               bytes_left_nxt  = '0;
               if (tag == CH_NONE || data_byte != tag) begin
                  err = 1'b1; result.status = ST_BAD_TAG;
               end else begin
                  nxt.phase = PH_COLON;
               end
            end
         endcase

         if (err) begin
            emit = 1'b1; done = 1'b1;
            result.value        = 64'd0;
            result.content_byte = 8'd0;
            result.last         = 1'b1;
            nxt.skipping        = !end_of_data;
         end else if (!done && end_of_data) begin
            // buffer ends inside a token
            emit = 1'b1; done = 1'b1;
            result.status       = ST_TRUNCATED;
            result.value        = 64'd0;
            result.content_byte = 8'd0;
            result.last         = 1'b1;
         end
         if (done) begin
            nxt.phase = PH_TAG;
         end
      end
   end

endmodule

>>> hw/rtl/tagged_token_parser_unit.sv
// tagged_token_parser_unit: top level of the tagged token parser
// depends on ttp_pkg, ttp_channels (ttp_req_if, ttp_rsp_if), ttp_step
//
//   channel  dir  fields                                   transfer
//   req_ch   in   mode, data_byte, end_of_data             valid & ready
//   rsp_ch   out  status, value, content_byte, last        valid & ready
//
// one byte per cycle sustained while the response channel takes each record; a byte is held
// in the input register, and its record is written from there into the output register,
// which drives the response channel
// the per-byte state update (multiply by ten, add, limit compare) is combinational
// between the input register and the parser state, which sets the rate
// reset is synchronous, active high, and clears both valid bits and the parser state
// a stalled response only holds back bytes that produce a record; bytes
// that produce none keep flowing into the state

module tagged_token_parser_unit
   import ttp_pkg::*;
#(
   parameter logic [31:0] MAX_STRING_LEN = 32'd65535
) (
   input  logic       clock,
   input  logic       reset,
   ttp_req_if.sink    req_ch,
   ttp_rsp_if.source  rsp_ch
);

   // string length counter is as wide as the largest allowed length
   localparam int LEN_W = $clog2({1'b0, MAX_STRING_LEN} + 33'd1);

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [2:0]       in_mode_ff;
   logic [7:0]       in_byte_ff;
   logic             in_eod_ff;

   // parser state
   state_type        state_ff, state_in;
   logic [LEN_W-1:0] bytes_left_ff, bytes_left_in;

   // output register
   logic             out_valid_ff, out_valid_in;
   result_type       out_result_ff;

   // step results for the byte in the input register
   logic             emit;
   result_type       result;

   logic             out_free;
   logic             proc;
   logic             req_xfer;

   ttp_step #(
      .MAX_STRING_LEN (MAX_STRING_LEN),
      .LEN_W          (LEN_W)
   ) u_step (
      .cur            (state_ff),
      .bytes_left_cur (bytes_left_ff),
      .mode           (in_mode_ff),
      .data_byte      (in_byte_ff),
      .end_of_data    (in_eod_ff),
      .nxt            (state_in),
      .bytes_left_nxt (bytes_left_in),
      .emit           (emit),
      .result         (result)
   );

   // output slot is free when empty or being drained this cycle
   assign out_free = !out_valid_ff || rsp_ch.ready;
   // the held byte is consumed if it makes no record or the slot can take one
   assign proc     = in_valid_ff && (out_free || !emit);
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || proc;

   assign in_valid_in  = req_xfer || (in_valid_ff && !proc);
   assign out_valid_in = (proc && emit) || (out_valid_ff && !rsp_ch.ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= STATE_RESET;
         bytes_left_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (proc) begin
            state_ff      <= state_in;
            bytes_left_ff <= bytes_left_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff <= req_ch.mode;
         in_byte_ff <= req_ch.data_byte;
         in_eod_ff  <= req_ch.end_of_data;
      end
      if (proc && emit) begin
         out_result_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_result_ff.status;
   assign rsp_ch.value        = out_result_ff.value;
   assign rsp_ch.content_byte = out_result_ff.content_byte;
   assign rsp_ch.last         = out_result_ff.last;

   // only string bytes leave last low
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_result_ff.last == (out_result_ff.status != ST_STRING_BYTE)))
      else $error("last flag disagrees with status");

   // a skipped byte never produces a record
   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      (proc && state_ff.skipping) |-> !emit)
      else $error("record produced while skipping");

   // a held byte that is not consumed stays in the input register
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input byte lost");

   // string body is only entered with bytes still to come
   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_SBODY) |-> (bytes_left_ff != '0))
      else $error("string body with zero bytes left");

   // a stalled record is never overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> (out_valid_ff && $stable(out_result_ff)))
      else $error("pending record overwritten");

endmodule
